[rtl/pts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, constants and table functions of the tone sequencer.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int PTS_NOTE_SLOTS       = 64;
    localparam int PTS_EFFECT_SLOTS     = 17;
    localparam int PTS_MAX_EFFECT_NOTES = 7;

    localparam int PTS_MODE_W   = 2;
    localparam int PTS_ID_W     = 5;
    localparam int PTS_FREQ_W   = 16;
    localparam int PTS_VOL_W    = 8;
    localparam int PTS_MS_W     = 16;
    localparam int PTS_FRAME_W  = 10;
    localparam int PTS_POS_W    = 4;
    localparam int PTS_START_W  = 6;
    localparam int PTS_PRIO_W   = 4;
    localparam int PTS_PADDR_W  = 3;
    localparam int PTS_PDATA_W  = 32;

    localparam logic [PTS_FRAME_W-1:0] PTS_FRAME_RESET = 10'd40;

    localparam logic [PTS_MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [PTS_MODE_W-1:0] MODE_PLAY = 2'd1;
    localparam logic [PTS_MODE_W-1:0] MODE_STOP = 2'd2;

    localparam logic REG_FRAME_MS = 1'b0;

    typedef struct packed {
        logic [PTS_START_W-1:0] start;
        logic [PTS_POS_W-1:0]   len;
        logic [PTS_PRIO_W-1:0]  prio;
        logic [PTS_VOL_W-1:0]   vol;
    } t_effect;

    typedef struct packed {
        logic [PTS_FREQ_W-1:0] freq;
        logic [PTS_MS_W-1:0]   ms;
    } t_note;

    typedef struct packed {
        logic                  valid;
        logic [PTS_FREQ_W-1:0] freq;
        logic [PTS_VOL_W-1:0]  volume;
    } t_result;

    function automatic t_effect pts_effect_rd(input logic [PTS_ID_W-1:0] id);
        t_effect e;
        e = '0;
        if (32'(id) < PTS_EFFECT_SLOTS) begin
            unique case (id)
                5'd1:    e = '{6'd0,  4'd1, 4'd1, 8'd120};
                5'd2:    e = '{6'd1,  4'd2, 4'd2, 8'd150};
                5'd3:    e = '{6'd3,  4'd2, 4'd1, 8'd90};
                5'd4:    e = '{6'd5,  4'd1, 4'd1, 8'd110};
                5'd5:    e = '{6'd6,  4'd3, 4'd2, 8'd160};
                5'd6:    e = '{6'd9,  4'd4, 4'd4, 8'd210};
                5'd7:    e = '{6'd13, 4'd3, 4'd5, 8'd220};
                5'd8:    e = '{6'd16, 4'd3, 4'd3, 8'd150};
                5'd9:    e = '{6'd19, 4'd5, 4'd5, 8'd220};
                5'd10:   e = '{6'd24, 4'd4, 4'd4, 8'd180};
                5'd11:   e = '{6'd28, 4'd4, 4'd3, 8'd150};
                5'd12:   e = '{6'd32, 4'd7, 4'd5, 8'd200};
                5'd13:   e = '{6'd39, 4'd7, 4'd6, 8'd160};
                5'd14:   e = '{6'd46, 4'd4, 4'd6, 8'd190};
                5'd15:   e = '{6'd50, 4'd7, 4'd6, 8'd190};
                5'd16:   e = '{6'd57, 4'd2, 4'd4, 8'd140};
                default: e = '0;
            endcase
        end
        if (32'(e.len) > PTS_MAX_EFFECT_NOTES) begin
            e.len = PTS_POS_W'(PTS_MAX_EFFECT_NOTES);
        end
        return e;
    endfunction

    function automatic t_note pts_note_rd(input logic [PTS_START_W-1:0] idx);
        t_note n;
        unique case (idx)
            6'd0:  n = '{16'd1200, 16'd30};
            6'd1:  n = '{16'd900,  16'd40};   6'd2:  n = '{16'd1400, 16'd60};
            6'd3:  n = '{16'd1900, 16'd20};   6'd4:  n = '{16'd1200, 16'd20};
            6'd5:  n = '{16'd300,  16'd30};
            6'd6:  n = '{16'd700,  16'd40};   6'd7:  n = '{16'd350,  16'd40};
            6'd8:  n = '{16'd180,  16'd60};
            6'd9:  n = '{16'd900,  16'd40};   6'd10: n = '{16'd500,  16'd60};
            6'd11: n = '{16'd250,  16'd80};   6'd12: n = '{16'd120,  16'd120};
            6'd13: n = '{16'd200,  16'd60};   6'd14: n = '{16'd0,    16'd30};
            6'd15: n = '{16'd150,  16'd90};
            6'd16: n = '{16'd800,  16'd40};   6'd17: n = '{16'd1100, 16'd40};
            6'd18: n = '{16'd1500, 16'd60};
            6'd19: n = '{16'd1800, 16'd30};   6'd20: n = '{16'd1400, 16'd30};
            6'd21: n = '{16'd900,  16'd40};   6'd22: n = '{16'd400,  16'd80};
            6'd23: n = '{16'd150,  16'd120};
            6'd24: n = '{16'd1000, 16'd60};   6'd25: n = '{16'd1300, 16'd60};
            6'd26: n = '{16'd1700, 16'd60};   6'd27: n = '{16'd2100, 16'd100};
            6'd28: n = '{16'd900,  16'd60};   6'd29: n = '{16'd0,    16'd30};
            6'd30: n = '{16'd900,  16'd60};   6'd31: n = '{16'd1350, 16'd100};
            6'd32: n = '{16'd600,  16'd100};  6'd33: n = '{16'd0,    16'd60};
            6'd34: n = '{16'd600,  16'd100};  6'd35: n = '{16'd0,    16'd60};
            6'd36: n = '{16'd600,  16'd100};  6'd37: n = '{16'd0,    16'd60};
            6'd38: n = '{16'd450,  16'd200};
            6'd39: n = '{16'd660,  16'd90};   6'd40: n = '{16'd880,  16'd90};
            6'd41: n = '{16'd990,  16'd90};   6'd42: n = '{16'd1320, 16'd180};
            6'd43: n = '{16'd0,    16'd60};   6'd44: n = '{16'd990,  16'd90};
            6'd45: n = '{16'd1320, 16'd240};
            6'd46: n = '{16'd880,  16'd120};  6'd47: n = '{16'd830,  16'd120};
            6'd48: n = '{16'd780,  16'd120};  6'd49: n = '{16'd520,  16'd300};
            6'd50: n = '{16'd1050, 16'd80};   6'd51: n = '{16'd1320, 16'd80};
            6'd52: n = '{16'd1580, 16'd80};   6'd53: n = '{16'd2100, 16'd160};
            6'd54: n = '{16'd0,    16'd40};   6'd55: n = '{16'd1580, 16'd80};
            6'd56: n = '{16'd2100, 16'd240};
            6'd57: n = '{16'd1400, 16'd40};   6'd58: n = '{16'd700,  16'd40};
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

[rtl/pts_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_if
// Valid/ready channels of the tone sequencer: command in, tone out.
// ----------------------------------------------------------------------------
interface pts_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [pts_pkg::PTS_MODE_W-1:0] mode;
    logic [pts_pkg::PTS_ID_W-1:0]   effect_id;

    modport source (output valid, output mode, output effect_id, input ready);
    modport sink   (input valid, input mode, input effect_id, output ready);
endinterface

interface pts_tone_if;
    logic                           valid;
    logic                           ready;
    logic [pts_pkg::PTS_FREQ_W-1:0] tone_freq;
    logic [pts_pkg::PTS_VOL_W-1:0]  tone_volume;

    modport source (output valid, output tone_freq, output tone_volume, input ready);
    modport sink   (input valid, input tone_freq, input tone_volume, output ready);
endinterface
`default_nettype wire

[rtl/priority_tone_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// priority_tone_sequencer
// Single-channel buzzer sequencer with priority-based effect preemption.
// ----------------------------------------------------------------------------
// Accepts one command transaction per clock (tick, play or stop) and gives
// at most one tone transaction for it: the command is held in the input
// register, then one pass through the effect and note tables and the
// timer subtract is written into the result register. Throughput is one
// transaction per cycle while the tone sink keeps ready high; the result
// register is the only stall point. frame_ms sits at APB byte address 0.
module priority_tone_sequencer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    pts_cmd_if.sink                               i_cmd,
    pts_tone_if.source                            o_tone,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pts_pkg::PTS_PADDR_W-1:0]  paddr,
    input  wire logic [pts_pkg::PTS_PDATA_W-1:0]  pwdata,
    output logic      [pts_pkg::PTS_PDATA_W-1:0]  prdata,
    output logic                                  pready
);
    import pts_pkg::*;

    logic [PTS_FRAME_W-1:0] r_frame_ms;
    logic                   r_in_valid;
    logic [PTS_MODE_W-1:0]  r_in_mode;
    logic [PTS_ID_W-1:0]    r_in_id;
    logic                   r_out_valid;
    logic [PTS_FREQ_W-1:0]  r_out_freq;
    logic [PTS_VOL_W-1:0]   r_out_vol;
    logic                   w_advance;
    logic                   w_fire;
    t_result                w_res;

    assign pready = 1'b1;
    assign prdata = (paddr[PTS_PADDR_W-1] == REG_FRAME_MS) ?
                    PTS_PDATA_W'(r_frame_ms) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_ms <= PTS_FRAME_RESET;
        end else if (psel && penable && pwrite &&
                     paddr[PTS_PADDR_W-1] == REG_FRAME_MS) begin
            r_frame_ms <= pwdata[PTS_FRAME_W-1:0];
        end
    end

    assign w_advance   = !r_out_valid || o_tone.ready;
    assign w_fire      = r_in_valid && w_advance;
    assign i_cmd.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_mode <= i_cmd.mode;
            r_in_id   <= i_cmd.effect_id;
        end
    end

    pts_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_mode      (r_in_mode),
        .i_effect_id (r_in_id),
        .i_frame_ms  (r_frame_ms),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res.valid;
        end else if (o_tone.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res.valid) begin
            r_out_freq <= w_res.freq;
            r_out_vol  <= w_res.volume;
        end
    end

    assign o_tone.valid       = r_out_valid;
    assign o_tone.tone_freq   = r_out_freq;
    assign o_tone.tone_volume = r_out_vol;

endmodule
`default_nettype wire

[rtl/pts_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pts_core
// Channel state and the per-transaction step: play, stop, frame tick.
// ----------------------------------------------------------------------------
module pts_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_fire,
    input  wire logic [pts_pkg::PTS_MODE_W-1:0]  i_mode,
    input  wire logic [pts_pkg::PTS_ID_W-1:0]    i_effect_id,
    input  wire logic [pts_pkg::PTS_FRAME_W-1:0] i_frame_ms,
    output pts_pkg::t_result                     o_res
);
    import pts_pkg::*;

    localparam int DIFF_W = PTS_MS_W + 2;
    localparam int IDX_W  = PTS_START_W + 1;

    logic                  r_active, n_active;
    t_effect               r_eff, n_eff;
    logic [PTS_POS_W-1:0]  r_pos, n_pos;
    logic [PTS_MS_W-1:0]   r_rem, n_rem;

    t_effect               w_new_eff;
    t_note                 w_note;
    logic [PTS_POS_W-1:0]  w_pos_inc;
    logic [IDX_W-1:0]      w_idx;
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] w_sum;

    assign w_new_eff = pts_effect_rd(i_effect_id);
    assign w_pos_inc = r_pos + PTS_POS_W'(1);
    assign w_idx     = IDX_W'(r_eff.start) + IDX_W'(w_pos_inc);
    assign w_note    = pts_note_rd(w_idx[PTS_START_W-1:0]);
    assign w_diff    = $signed({2'b00, r_rem}) - $signed(DIFF_W'(i_frame_ms));
    assign w_sum     = w_diff + $signed({2'b00, w_note.ms});

    always_comb begin
        n_active = r_active;
        n_eff    = r_eff;
        n_pos    = r_pos;
        n_rem    = r_rem;
        o_res    = '0;
        if (i_fire) begin
            unique case (i_mode)
                MODE_PLAY: begin
                    if (w_new_eff.len != '0 &&
                        !(r_active && w_new_eff.prio < r_eff.prio)) begin
                        n_active = 1'b1;
                        n_eff    = w_new_eff;
                        n_pos    = '1;
                        n_rem    = '0;
                    end
                end
                MODE_STOP: begin
                    n_active    = 1'b0;
                    o_res.valid = 1'b1;
                end
                MODE_TICK: begin
                    if (r_active) begin
                        if (!w_diff[DIFF_W-1] && w_diff != '0) begin
                            n_rem = w_diff[PTS_MS_W-1:0];
                        end else begin
                            n_pos       = w_pos_inc;
                            o_res.valid = 1'b1;
                            if (w_pos_inc >= r_eff.len ||
                                w_idx >= IDX_W'(PTS_NOTE_SLOTS)) begin
                                n_active = 1'b0;
                            end else begin
                                if (w_sum[DIFF_W-1] || w_sum == '0) begin
                                    n_rem = w_note.ms;
                                end else begin
                                    n_rem = w_sum[PTS_MS_W-1:0];
                                end
                                o_res.freq   = w_note.freq;
                                o_res.volume = (w_note.freq != '0) ? r_eff.vol : '0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_eff    <= '0;
            r_pos    <= '1;
            r_rem    <= '0;
        end else begin
            r_active <= n_active;
            r_eff    <= n_eff;
            r_pos    <= n_pos;
            r_rem    <= n_rem;
        end
    end

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_mode == MODE_STOP |=> !r_active)
        else $error("stop left channel active");

    a_active_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> r_eff.len != '0)
        else $error("active channel with empty effect");

    a_tone_keeps_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.volume != '0 |=> r_active)
        else $error("audible tone but channel inactive");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |-> !o_res.valid)
        else $error("result without transaction");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_active))
        else $error("state change without transaction");

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for priority_tone_sequencer.
// A queue-fed driver sends tick/play/stop and unused-mode commands and a monitor
// compares every tone transaction against an in-bench sequencer model. The run
// covers a short directed opening and then random effect runs under several
// frame_ms settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb;
    import pts_pkg::*;

    localparam logic [PTS_MODE_W-1:0]  MODE_UNUSED  = 2'd3;
    localparam logic [PTS_PADDR_W-1:0] FRAME_ADDR   = {REG_FRAME_MS, 2'b00};
    localparam int                     ITEMS_PHASE  = 228;
    localparam int                     STALL_LIMIT  = 5000;
    localparam int                     NUM_PHASES   = 8;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_kind_e;

    typedef struct {
        logic [PTS_MODE_W-1:0] mode;
        logic [PTS_ID_W-1:0]   id;
        bit                    hold;
    } cmd_item_t;

    typedef struct packed {
        logic [PTS_FREQ_W-1:0] freq;
        logic [PTS_VOL_W-1:0]  volume;
    } tone_t;

    logic i_clk;
    logic i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PTS_PADDR_W-1:0] paddr;
    logic [PTS_PDATA_W-1:0] pwdata;
    wire  [PTS_PDATA_W-1:0] prdata;
    wire                    pready;

    pts_cmd_if  cmd_ch ();
    pts_tone_if tone_ch ();

    priority_tone_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_tone  (tone_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cmd_item_t pending_q[$];
    tone_t     tone_exp_q[$];

    // sequencer model state
    bit                   seq_active = 1'b0;
    logic [PTS_ID_W-1:0]  seq_effect = '0;
    logic [PTS_POS_W-1:0] seq_pos    = 4'hF;
    int                   seq_left   = 0;
    int                   seq_frame  = int'(PTS_FRAME_RESET);

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  cmd_taken      = 1'b0;
    int  errors         = 0;
    int  tones_checked  = 0;
    int  n_play         = 0;
    int  n_tick         = 0;
    int  n_stop         = 0;
    int  n_unused       = 0;
    int  quiet_cycles   = 0;

    int         phase_frame [NUM_PHASES] = '{40, 1, 1023, 0, 1000, -1, -1, 40};
    idle_kind_e phase_idle  [NUM_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                             IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // effect descriptors: {start, len, prio, vol}
    function automatic t_effect effect_of(input logic [PTS_ID_W-1:0] id);
        logic [21:0] w;
        t_effect     e;
        case (id)
            5'd1:    w = {6'd0,  4'd1, 4'd1, 8'd120};
            5'd2:    w = {6'd1,  4'd2, 4'd2, 8'd150};
            5'd3:    w = {6'd3,  4'd2, 4'd1, 8'd90};
            5'd4:    w = {6'd5,  4'd1, 4'd1, 8'd110};
            5'd5:    w = {6'd6,  4'd3, 4'd2, 8'd160};
            5'd6:    w = {6'd9,  4'd4, 4'd4, 8'd210};
            5'd7:    w = {6'd13, 4'd3, 4'd5, 8'd220};
            5'd8:    w = {6'd16, 4'd3, 4'd3, 8'd150};
            5'd9:    w = {6'd19, 4'd5, 4'd5, 8'd220};
            5'd10:   w = {6'd24, 4'd4, 4'd4, 8'd180};
            5'd11:   w = {6'd28, 4'd4, 4'd3, 8'd150};
            5'd12:   w = {6'd32, 4'd7, 4'd5, 8'd200};
            5'd13:   w = {6'd39, 4'd7, 4'd6, 8'd160};
            5'd14:   w = {6'd46, 4'd4, 4'd6, 8'd190};
            5'd15:   w = {6'd50, 4'd7, 4'd6, 8'd190};
            5'd16:   w = {6'd57, 4'd2, 4'd4, 8'd140};
            default: w = '0;
        endcase
        e = t_effect'(w);
        if (int'(e.len) > PTS_MAX_EFFECT_NOTES) begin
            e.len = PTS_POS_W'(PTS_MAX_EFFECT_NOTES);
        end
        return e;
    endfunction

    // note table: {freq, ms}
    function automatic t_note note_of(input int idx);
        logic [31:0] w;
        case (idx)
            0:  w = {16'd1200, 16'd30};
            1:  w = {16'd900,  16'd40};   2:  w = {16'd1400, 16'd60};
            3:  w = {16'd1900, 16'd20};   4:  w = {16'd1200, 16'd20};
            5:  w = {16'd300,  16'd30};
            6:  w = {16'd700,  16'd40};   7:  w = {16'd350,  16'd40};
            8:  w = {16'd180,  16'd60};
            9:  w = {16'd900,  16'd40};   10: w = {16'd500,  16'd60};
            11: w = {16'd250,  16'd80};   12: w = {16'd120,  16'd120};
            13: w = {16'd200,  16'd60};   14: w = {16'd0,    16'd30};
            15: w = {16'd150,  16'd90};
            16: w = {16'd800,  16'd40};   17: w = {16'd1100, 16'd40};
            18: w = {16'd1500, 16'd60};
            19: w = {16'd1800, 16'd30};   20: w = {16'd1400, 16'd30};
            21: w = {16'd900,  16'd40};   22: w = {16'd400,  16'd80};
            23: w = {16'd150,  16'd120};
            24: w = {16'd1000, 16'd60};   25: w = {16'd1300, 16'd60};
            26: w = {16'd1700, 16'd60};   27: w = {16'd2100, 16'd100};
            28: w = {16'd900,  16'd60};   29: w = {16'd0,    16'd30};
            30: w = {16'd900,  16'd60};   31: w = {16'd1350, 16'd100};
            32: w = {16'd600,  16'd100};  33: w = {16'd0,    16'd60};
            34: w = {16'd600,  16'd100};  35: w = {16'd0,    16'd60};
            36: w = {16'd600,  16'd100};  37: w = {16'd0,    16'd60};
            38: w = {16'd450,  16'd200};
            39: w = {16'd660,  16'd90};   40: w = {16'd880,  16'd90};
            41: w = {16'd990,  16'd90};   42: w = {16'd1320, 16'd180};
            43: w = {16'd0,    16'd60};   44: w = {16'd990,  16'd90};
            45: w = {16'd1320, 16'd240};
            46: w = {16'd880,  16'd120};  47: w = {16'd830,  16'd120};
            48: w = {16'd780,  16'd120};  49: w = {16'd520,  16'd300};
            50: w = {16'd1050, 16'd80};   51: w = {16'd1320, 16'd80};
            52: w = {16'd1580, 16'd80};   53: w = {16'd2100, 16'd160};
            54: w = {16'd0,    16'd40};   55: w = {16'd1580, 16'd80};
            56: w = {16'd2100, 16'd240};
            57: w = {16'd1400, 16'd40};   58: w = {16'd700,  16'd40};
            default: w = '0;
        endcase
        return t_note'(w);
    endfunction

    // advance the sequencer model by one command
    function automatic void sequence_step(input logic [PTS_MODE_W-1:0] mode,
                                          input logic [PTS_ID_W-1:0] id,
                                          output bit emits, output tone_t tone);
        t_effect fresh;
        t_effect cur;
        t_note   nt;
        int      idx;
        emits = 1'b0;
        tone  = '0;
        case (mode)
            MODE_PLAY: begin
                fresh = effect_of(id);
                cur   = effect_of(seq_effect);
                if (fresh.len != 0 && !(seq_active && fresh.prio < cur.prio)) begin
                    seq_active = 1'b1;
                    seq_effect = id;
                    seq_pos    = 4'hF;
                    seq_left   = 0;
                end
            end
            MODE_STOP: begin
                seq_active = 1'b0;
                emits      = 1'b1;
            end
            MODE_TICK: begin
                if (seq_active) begin
                    seq_left = seq_left - seq_frame;
                    if (seq_left <= 0) begin
                        cur     = effect_of(seq_effect);
                        seq_pos = seq_pos + 4'd1;
                        idx     = int'(cur.start) + int'(seq_pos);
                        emits   = 1'b1;
                        if (seq_pos >= cur.len || idx >= PTS_NOTE_SLOTS) begin
                            seq_active = 1'b0;
                        end else begin
                            nt       = note_of(idx);
                            seq_left = seq_left + int'(nt.ms);
                            if (seq_left <= 0) begin
                                seq_left = int'(nt.ms);
                            end
                            tone.freq   = nt.freq;
                            tone.volume = (nt.freq != 0) ? cur.vol : '0;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // command driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!(cmd_ch.valid && !cmd_taken)) begin
            if (pending_q.size() != 0 && !(pending_q[0].hold && tone_exp_q.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct) begin
                cmd_ch.valid     <= 1'b1;
                cmd_ch.mode      <= pending_q[0].mode;
                cmd_ch.effect_id <= pending_q[0].id;
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // tone sink
    always @(negedge i_clk) begin
        tone_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        tone_t got;
        tone_t want;
        bit    emits;
        if (!i_rst_n) begin
            cmd_taken    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;
            if (tone_ch.valid && tone_ch.ready) begin
                got = '{tone_ch.tone_freq, tone_ch.tone_volume};
                if (tone_exp_q.size() == 0) begin
                    $display("%0t: unexpected tone: expected none, got freq %0d vol %0d",
                             $time, got.freq, got.volume);
                    errors++;
                end else begin
                    want = tone_exp_q.pop_front();
                    if (got.freq !== want.freq) begin
                        $display("%0t: tone_freq mismatch: expected %0d, got %0d",
                                 $time, want.freq, got.freq);
                        errors++;
                    end
                    if (got.volume !== want.volume) begin
                        $display("%0t: tone_volume mismatch: expected %0d, got %0d",
                                 $time, want.volume, got.volume);
                        errors++;
                    end
                    tones_checked++;
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                sequence_step(cmd_ch.mode, cmd_ch.effect_id, emits, want);
                if (emits) begin
                    tone_exp_q.push_back(want);
                end
                case (cmd_ch.mode)
                    MODE_PLAY: n_play++;
                    MODE_TICK: n_tick++;
                    MODE_STOP: n_stop++;
                    default:   n_unused++;
                endcase
                if (pending_q.size() != 0) begin
                    void'(pending_q.pop_front());
                end
            end
            if ((cmd_ch.valid && cmd_ch.ready) || (tone_ch.valid && tone_ch.ready)
                || (psel && penable)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired, %0d commands pending, %0d tones outstanding",
                         $time, pending_q.size(), tone_exp_q.size());
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic apb_access(input bit wr, input logic [PTS_PADDR_W-1:0] addr,
                              input logic [PTS_PDATA_W-1:0] wdata,
                              output logic [PTS_PDATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_frame(input int want);
        logic [PTS_PDATA_W-1:0] rd;
        apb_access(1'b0, FRAME_ADDR, '0, rd);
        if (rd[PTS_FRAME_W-1:0] !== PTS_FRAME_W'(want)) begin
            $display("%0t: frame_ms readback mismatch: expected %0d, got %0d",
                     $time, want, rd[PTS_FRAME_W-1:0]);
            errors++;
        end
    endtask

    task automatic drain;
        while (pending_q.size() != 0 || tone_exp_q.size() != 0) @(posedge i_clk);
    endtask

    // reprogram frame_ms once the sequencer is quiet
    task automatic set_frame(input int value);
        logic [PTS_PDATA_W-1:0] rd;
        drain();
        repeat (6) @(posedge i_clk);
        apb_access(1'b1, FRAME_ADDR, PTS_PDATA_W'(value), rd);
        seq_frame = value;
        check_frame(value);
    endtask

    task automatic push_cmd(input logic [PTS_MODE_W-1:0] mode,
                            input logic [PTS_ID_W-1:0] id, input bit hold);
        cmd_item_t it;
        it.mode = mode;
        it.id   = id;
        it.hold = hold;
        pending_q.push_back(it);
    endtask

    // mostly play-then-ticks runs, with stray commands mixed in
    task automatic queue_random(input int n);
        int made;
        int run;
        bit first;
        logic [PTS_MODE_W-1:0] m;
        made  = 0;
        first = 1'b1;
        while (made < n) begin
            if ($urandom_range(0, 99) < 75) begin
                push_cmd(MODE_PLAY, PTS_ID_W'($urandom_range(1, PTS_EFFECT_SLOTS - 1)),
                         first || $urandom_range(0, 99) < 3);
                made++;
                run = $urandom_range(2, 40);
                for (int k = 0; k < run; k++) begin
                    push_cmd(MODE_TICK, PTS_ID_W'($urandom_range(0, 31)), 1'b0);
                    made++;
                end
                if ($urandom_range(0, 4) == 0) begin
                    push_cmd(MODE_STOP, PTS_ID_W'($urandom_range(0, 31)), 1'b0);
                    made++;
                end
                first = 1'b0;
            end else begin
                m = PTS_MODE_W'($urandom_range(0, 3));
                push_cmd(m, PTS_ID_W'($urandom_range(0, 31)), 1'b0);
                if (m != MODE_UNUSED) begin
                    made++;
                end
            end
        end
    endtask

    initial begin
        int frame;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.mode      = MODE_TICK;
        cmd_ch.effect_id = '0;
        tone_ch.ready    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_frame(int'(PTS_FRAME_RESET));

        // directed opening at the reset frame_ms
        push_cmd(MODE_TICK,   5'd0,  1'b0);  // idle channel: silent
        push_cmd(MODE_STOP,   5'd0,  1'b0);  // stop while idle still emits
        push_cmd(MODE_UNUSED, 5'd31, 1'b0);
        push_cmd(MODE_PLAY,   5'd0,  1'b0);  // empty ids
        push_cmd(MODE_PLAY,   5'd17, 1'b0);
        push_cmd(MODE_PLAY,   5'd31, 1'b0);
        push_cmd(MODE_PLAY,   5'd16, 1'b0);
        push_cmd(MODE_TICK,   5'd31, 1'b0);
        push_cmd(MODE_PLAY,   5'd1,  1'b0);  // lower priority, dropped
        push_cmd(MODE_TICK,   5'd0,  1'b0);
        push_cmd(MODE_TICK,   5'd0,  1'b0);  // runs off the end
        push_cmd(MODE_TICK,   5'd0,  1'b0);
        push_cmd(MODE_PLAY,   5'd7,  1'b0);  // contains a rest
        push_cmd(MODE_TICK,   5'd0,  1'b0);
        push_cmd(MODE_TICK,   5'd0,  1'b0);
        push_cmd(MODE_TICK,   5'd0,  1'b0);
        push_cmd(MODE_TICK,   5'd0,  1'b0);
        push_cmd(MODE_PLAY,   5'd14, 1'b0);  // preempts
        push_cmd(MODE_PLAY,   5'd13, 1'b0);  // equal priority replaces
        push_cmd(MODE_TICK,   5'd0,  1'b0);
        push_cmd(MODE_STOP,   5'd0,  1'b0);
        push_cmd(MODE_TICK,   5'd0,  1'b0);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            frame = (phase_frame[ph] < 0) ? $urandom_range(5, 200) : phase_frame[ph];
            if (ph != 0) begin
                set_frame(frame);
            end
            send_idle_pct  = (phase_idle[ph] == IDLE_SEND) ? 81 :
                             (phase_idle[ph] == IDLE_BOTH) ? 32 : 0;
            recv_stall_pct = (phase_idle[ph] == IDLE_RECV) ? 81 :
                             (phase_idle[ph] == IDLE_BOTH) ? 32 : 0;
            queue_random(ITEMS_PHASE);
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("tb: %0d plays, %0d ticks, %0d stops, %0d unused-mode commands sent",
                 n_play, n_tick, n_stop, n_unused);
        $display("tb: %0d tones checked over %0d frame_ms settings incl. 0, 1, 1000, 1023",
                 tones_checked, NUM_PHASES);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[priority_tone_sequencer.f]
rtl/pts_pkg.sv
rtl/pts_if.sv
rtl/pts_core.sv
rtl/priority_tone_sequencer.sv
verif/tb.sv
